>>> rtl/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int COORD_W   = 20;
    localparam int ABS_W     = COORD_W;
    localparam int SQ_W      = 2 * ABS_W;
    localparam int IDENT_W   = 32;
    localparam int DIST_W    = 44;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic signed [IDENT_W-1:0] ident;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } node_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    // one scan slot handed to the distance unit
    typedef struct packed {
        logic             issue;
        logic             cand;
        logic             last;
        logic [IDX_W-1:0] index;
    } scan_ctl_t;

    typedef struct packed {
        logic              found;
        node_t             node;
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] dist_sq;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_HOLD
    } state_t;

endpackage

>>> rtl/nps_cell.sv
`timescale 1ns / 1ps

module nps_cell (
    input  logic          clk,
    input  logic          wr_en,
    input  nps_pkg::node_t wr_node,
    input  logic          shift,
    input  nps_pkg::node_t from_next,
    output nps_pkg::node_t node
);
    import nps_pkg::*;

    node_t node_reg;

    // a write lands in this slot; otherwise rotate towards the head
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_reg <= wr_node;
        end
        else if (shift)
        begin
            node_reg <= from_next;
        end
    end

    assign node = node_reg;

endmodule

>>> rtl/nps_dist.sv
`timescale 1ns / 1ps

module nps_dist (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  nps_pkg::scan_ctl_t ctl,
    input  nps_pkg::node_t     head,
    input  nps_pkg::point_t    qpoint,
    output logic               done,
    output nps_pkg::result_t   result
);
    import nps_pkg::*;

    logic signed [COORD_W:0] dx, dy, dz;
    logic [ABS_W-1:0]        ax_next, ay_next, az_next;
    logic [ABS_W-1:0]        ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]         sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0]       sum;

    scan_ctl_t s1_ctl_reg, s2_ctl_reg;
    node_t     s1_node_reg, s2_node_reg;

    logic              found_reg;
    node_t             best_node_reg;
    logic [IDX_W-1:0]  best_index_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic              done_reg;

    // stage 1: coordinate differences and magnitudes
    always_comb
    begin
        dx = {qpoint.x[COORD_W-1], qpoint.x} - {head.x[COORD_W-1], head.x};
        dy = {qpoint.y[COORD_W-1], qpoint.y} - {head.y[COORD_W-1], head.y};
        dz = {qpoint.z[COORD_W-1], qpoint.z} - {head.z[COORD_W-1], head.z};
        ax_next = dx[COORD_W] ? ABS_W'(-dx) : dx[ABS_W-1:0];
        ay_next = dy[COORD_W] ? ABS_W'(-dy) : dy[ABS_W-1:0];
        az_next = dz[COORD_W] ? ABS_W'(-dz) : dz[ABS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            s2_ctl_reg <= s1_ctl_reg;
            done_reg   <= s2_ctl_reg.issue && s2_ctl_reg.last;
            if (start)
            begin
                found_reg <= 1'b0;
            end
            else if (s2_ctl_reg.issue && s2_ctl_reg.cand)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        az_reg      <= az_next;
        s1_node_reg <= head;
        sx_reg      <= ax_reg * ax_reg;
        sy_reg      <= ay_reg * ay_reg;
        sz_reg      <= az_reg * az_reg;
        s2_node_reg <= s1_node_reg;
    end

    // stage 3: sum and keep the strict minimum, earliest slot on ties
    assign sum = DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);

    always_ff @(posedge clk)
    begin
        if (s2_ctl_reg.issue && s2_ctl_reg.cand && (!found_reg || sum < best_dist_reg))
        begin
            best_dist_reg  <= sum;
            best_index_reg <= s2_ctl_reg.index;
            best_node_reg  <= s2_node_reg;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        result = '0;
        if (found_reg)
        begin
            result.found   = 1'b1;
            result.node    = best_node_reg;
            result.index   = best_index_reg;
            result.dist_sq = best_dist_reg;
        end
    end

endmodule

>>> rtl/nearest_point_search_top.sv
`timescale 1ns / 1ps

// Nearest node search over a table of up to 64 nodes (id plus 3D position).
//
// Input channel (in_valid / in_stall) carries cmd, slot, node_ident and
// coord_x/y/z. A write (cmd 0) stores the node in the given slot and gives
// no result. A query (cmd 1) gives one result on the output
// channel (out_valid / out_stall): found, best_ident, best_index, best_x/y/z
// and best_dist_sq, all zero when node_count is zero.
// The table sits in a ring of 64 cells that rotates one node per cycle past
// a single distance unit, so a query always scans all 64 cells, then passes
// the distance pipeline and the result load before out_valid rises; the next
// item is taken only after that load.
// in_stall is high from a query transfer until its result is loaded.
// node_count is written through cfg_wr_en / cfg_wr_data, by the user only while
// idle (the block does not enforce it); values above 64 scan all 64 slots.
// Reset clears the control state and node_count; table contents stay
// undefined until written. A stalled result holds in the output register;
// new items are still taken meanwhile, and a finished query waits until the
// output register frees.
module nearest_point_search_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [nps_pkg::CNT_W-1:0]           cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic [nps_pkg::IDX_W-1:0]           slot,
    input  logic signed [nps_pkg::IDENT_W-1:0]  node_ident,
    input  logic signed [nps_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [nps_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [nps_pkg::COORD_W-1:0]  coord_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic signed [nps_pkg::IDENT_W-1:0]  best_ident,
    output logic [nps_pkg::IDX_W-1:0]           best_index,
    output logic signed [nps_pkg::COORD_W-1:0]  best_x,
    output logic signed [nps_pkg::COORD_W-1:0]  best_y,
    output logic signed [nps_pkg::COORD_W-1:0]  best_z,
    output logic [nps_pkg::DIST_W-1:0]          best_dist_sq
);
    import nps_pkg::*;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] node_count_reg;
    logic [CNT_W-1:0] limit_reg, limit_next;
    point_t           q_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg;

    logic      in_xfer, wr_xfer, query_xfer, out_free, load;
    logic      shift;
    scan_ctl_t ctl;
    node_t     wr_node;
    node_t     ring [MAX_NODES];
    logic      done;
    result_t   result;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign wr_xfer    = in_xfer && (cmd == CMD_WRITE);
    assign query_xfer = in_xfer && (cmd == CMD_QUERY);
    assign out_free   = !out_valid_reg || !out_stall;
    assign shift      = (state_reg == ST_SCAN);

    assign wr_node.ident = node_ident;
    assign wr_node.x     = coord_x;
    assign wr_node.y     = coord_y;
    assign wr_node.z     = coord_z;

    for (genvar k = 0; k < MAX_NODES; k++)
    begin : g_ring
        nps_cell u_cell (
            .clk       (clk),
            .wr_en     (wr_xfer && (slot == IDX_W'(k))),
            .wr_node   (wr_node),
            .shift     (shift),
            .from_next (ring[(k + 1) % MAX_NODES]),
            .node      (ring[k])
        );
    end

    always_comb
    begin
        ctl.issue = shift;
        ctl.cand  = ({1'b0, cnt_reg} < limit_reg);
        ctl.last  = (cnt_reg == IDX_W'(MAX_NODES - 1));
        ctl.index = cnt_reg;
    end

    nps_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (query_xfer),
        .ctl    (ctl),
        .head   (ring[0]),
        .qpoint (q_reg),
        .done   (done),
        .result (result)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        limit_next     = limit_reg;
        load           = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_xfer)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                    limit_next = (node_count_reg > CNT_W'(MAX_NODES)) ?
                                 CNT_W'(MAX_NODES) : node_count_reg;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (ctl.last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (done)
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            limit_reg      <= '0;
            node_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    // hold the query point for the scan and the result until transfer
    always_ff @(posedge clk)
    begin
        if (query_xfer)
        begin
            q_reg.x <= coord_x;
            q_reg.y <= coord_y;
            q_reg.z <= coord_z;
        end
        if (load)
        begin
            out_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = out_reg.found;
    assign best_ident   = out_reg.node.ident;
    assign best_index   = out_reg.index;
    assign best_x       = out_reg.node.x;
    assign best_y       = out_reg.node.y;
    assign best_z       = out_reg.node.z;
    assign best_dist_sq = out_reg.dist_sq;

endmodule
